// ===== sv/fsca_pkg.sv =====
// ----------------------------------------------------------------------------
// fsca_pkg
// shared types, constants and helper functions of the fire spread core
// ----------------------------------------------------------------------------
`default_nettype none

package fsca_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int CELL_W   = 45;
    localparam int GW_W     = 9;
    localparam int GH_W     = 8;
    localparam int SUM_W    = 19;
    localparam int CIDX_W   = 4;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_GEN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] ST_UNBURNT = 2'd0;
    localparam logic [1:0] ST_BURNING = 2'd1;
    localparam logic [1:0] ST_BURNT   = 2'd2;

    localparam logic [2:0] MAT_WOOD     = 3'd2;
    localparam logic [2:0] MAT_LEAF     = 3'd3;
    localparam logic [2:0] MAT_DRY_LEAF = 3'd4;

    localparam logic [CIDX_W-1:0] REG_WOOD_STEPS  = 4'd0;
    localparam logic [CIDX_W-1:0] REG_LEAF_STEPS  = 4'd1;
    localparam logic [CIDX_W-1:0] REG_DRY_STEPS   = 4'd2;
    localparam logic [CIDX_W-1:0] REG_IGN_NEAR    = 4'd3;
    localparam logic [CIDX_W-1:0] REG_IGN_ALONE   = 4'd4;
    localparam logic [CIDX_W-1:0] REG_EMISSION    = 4'd5;
    localparam logic [CIDX_W-1:0] REG_GRID_WIDTH  = 4'd6;
    localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT = 4'd7;

    localparam logic [3:0] LAST_TAP = 4'd8;

    typedef struct packed {
        logic [1:0]  state;
        logic [2:0]  material;
        logic [31:0] energy;
        logic [7:0]  burn_time;
    } cell_t;

    typedef struct packed {
        logic [7:0]      wood_steps;
        logic [7:0]      leaf_steps;
        logic [7:0]      dry_steps;
        logic [31:0]     ign_near;
        logic [31:0]     ign_alone;
        logic [15:0]     emission;
        logic [GW_W-1:0] width_eff;
        logic [GH_W-1:0] height_eff;
    } cfg_t;

    function automatic logic is_fuel(input logic [2:0] m);
        return (m == MAT_WOOD) || (m == MAT_LEAF) || (m == MAT_DRY_LEAF);
    endfunction

    // tap 0 is the center, taps 1..8 the neighbours
    function automatic logic [1:0] tap_dx(input logic [3:0] k);
        logic [1:0] d;
        unique case (k)
            4'd1, 4'd2, 4'd3: d = 2'b11;
            4'd6, 4'd7, 4'd8: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] tap_dy(input logic [3:0] k);
        logic [1:0] d;
        unique case (k)
            4'd1, 4'd4, 4'd6: d = 2'b11;
            4'd3, 4'd5, 4'd8: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fsca_if.sv =====
// ----------------------------------------------------------------------------
// fsca channel interfaces
// command, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface fsca_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [1:0]  load_state;
    logic [2:0]  load_material;
    logic [31:0] load_energy;
    logic [7:0]  load_burn_time;
    modport source (output valid, kind, cell_col, cell_row, load_state, load_material,
                    load_energy, load_burn_time, input ready);
    modport sink (input valid, kind, cell_col, cell_row, load_state, load_material,
                  load_energy, load_burn_time, output ready);
endinterface

interface fsca_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply_kind;
    logic [1:0]  out_state;
    logic [2:0]  out_material;
    logic [31:0] out_energy;
    logic [7:0]  out_burn_time;
    modport source (output valid, reply_kind, out_state, out_material, out_energy,
                    out_burn_time, input ready);
    modport sink (input valid, reply_kind, out_state, out_material, out_energy,
                  out_burn_time, output ready);
endinterface

interface fsca_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fsca_ram.sv =====
// ----------------------------------------------------------------------------
// fsca_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module fsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/fsca_cfg.sv =====
// ----------------------------------------------------------------------------
// fsca_cfg
// configuration registers and effective grid extent
// ----------------------------------------------------------------------------
`default_nettype none

module fsca_cfg
    import fsca_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fsca_cfg_if.sink  cfg,
    output cfg_t      cfg_eff
);

    logic [7:0]      wood_reg, leaf_reg, dry_reg;
    logic [31:0]     near_reg, alone_reg;
    logic [15:0]     emis_reg;
    logic [GW_W-1:0] gw_reg;
    logic [GH_W-1:0] gh_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wood_reg  <= 8'd20;
            leaf_reg  <= 8'd1;
            dry_reg   <= 8'd1;
            near_reg  <= 32'd5000;
            alone_reg <= 32'd16000;
            emis_reg  <= 16'd2000;
            gw_reg    <= GW_W'(150);
            gh_reg    <= GH_W'(100);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WOOD_STEPS:  wood_reg  <= cfg.data[7:0];
                REG_LEAF_STEPS:  leaf_reg  <= cfg.data[7:0];
                REG_DRY_STEPS:   dry_reg   <= cfg.data[7:0];
                REG_IGN_NEAR:    near_reg  <= cfg.data;
                REG_IGN_ALONE:   alone_reg <= cfg.data;
                REG_EMISSION:    emis_reg  <= cfg.data[15:0];
                REG_GRID_WIDTH:  gw_reg    <= cfg.data[GW_W-1:0];
                REG_GRID_HEIGHT: gh_reg    <= cfg.data[GH_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg_eff.wood_steps = wood_reg;
        cfg_eff.leaf_steps = leaf_reg;
        cfg_eff.dry_steps  = dry_reg;
        cfg_eff.ign_near   = near_reg;
        cfg_eff.ign_alone  = alone_reg;
        cfg_eff.emission   = emis_reg;
        if (gw_reg == '0)
            cfg_eff.width_eff = GW_W'(1);
        else if (gw_reg > GW_W'(MAX_COLS))
            cfg_eff.width_eff = GW_W'(MAX_COLS);
        else
            cfg_eff.width_eff = gw_reg;
        if (gh_reg == '0)
            cfg_eff.height_eff = GH_W'(1);
        else if (gh_reg > GH_W'(MAX_ROWS))
            cfg_eff.height_eff = GH_W'(MAX_ROWS);
        else
            cfg_eff.height_eff = gh_reg;
    end

endmodule

`default_nettype wire

// ===== sv/fire_spread_cell_automaton_core.sv =====
// ----------------------------------------------------------------------------
// fire_spread_cell_automaton_core
// cell grid in one ram, load/read commands and a two pass generation sequencer
// ----------------------------------------------------------------------------
// load: response valid in the cycle after the command; read: via S_READ, after the registered ram read
// generation: two passes over width * height cells; each cell reads its
//   center and 8 neighbour taps through the single ram port, then writes back
// one command at a time; next command taken once the response slot frees
// reset clears control and sets configuration to defaults; cell contents are undefined until loaded
`default_nettype none

module fire_spread_cell_automaton_core
    import fsca_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsca_cmd_if.sink   cmd,
    fsca_rsp_if.source rsp,
    fsca_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_DRAIN, S_WRITE} state_t;

    cfg_t cfg_eff;

    state_t           state_reg;
    logic             pass_reg;
    logic [COL_W-1:0] x_reg;
    logic [ROW_W-1:0] y_reg;
    logic [3:0]       k_reg;
    logic             p_valid_reg;
    logic             p_inb_reg;
    logic [3:0]       p_k_reg;
    cell_t            center_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             nb_reg;

    logic        rsp_valid_reg;
    logic [1:0]  rsp_kind_reg;
    cell_t       rsp_cell_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    cell_t             rd_cell;

    logic            cmd_acc;
    logic            cmd_inside;
    logic [1:0]      dx_tap;
    logic [1:0]      dy_tap;
    logic [9:0]      nx;
    logic [8:0]      ny;
    logic            tap_inb;
    cell_t           new_cell;
    logic [32:0]     e_sum;
    logic [8:0]      t_inc;
    logic [7:0]      t_sat;
    logic [7:0]      steps;
    logic [31:0]     thr;
    logic            y_last;
    logic            x_last;

    fsca_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_eff (cfg_eff)
    );

    fsca_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_cell   = cell_t'(ram_rdata);
    assign cmd.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd_inside = ({1'b0, cmd.cell_col} < cfg_eff.width_eff) &&
                        ({1'b0, cmd.cell_row} < cfg_eff.height_eff);

    assign dx_tap = tap_dx(k_reg);
    assign dy_tap = tap_dy(k_reg);
    assign nx = {2'b00, x_reg} + {{8{dx_tap[1]}}, dx_tap};
    assign ny = {2'b00, y_reg} + {{7{dy_tap[1]}}, dy_tap};
    assign tap_inb = (nx < {1'b0, cfg_eff.width_eff}) && (ny < {1'b0, cfg_eff.height_eff});

    assign y_last = ({1'b0, y_reg} + 8'd1) >= cfg_eff.height_eff;
    assign x_last = ({1'b0, x_reg} + 9'd1) >= cfg_eff.width_eff;

    always_comb
    begin
        e_sum = {1'b0, center_reg.energy} + {14'd0, sum_reg};
        t_inc = {1'b0, center_reg.burn_time} + 9'd1;
        t_sat = t_inc[8] ? 8'hff : t_inc[7:0];
        priority case (center_reg.material)
            MAT_WOOD: steps = cfg_eff.wood_steps;
            MAT_LEAF: steps = cfg_eff.leaf_steps;
            default:  steps = cfg_eff.dry_steps;
        endcase
        thr = nb_reg ? cfg_eff.ign_near : cfg_eff.ign_alone;
        new_cell = center_reg;
        if (!pass_reg)
        begin
            new_cell.energy = e_sum[32] ? 32'hffff_ffff : e_sum[31:0];
        end
        else if (is_fuel(center_reg.material))
        begin
            if (center_reg.state == ST_BURNING)
            begin
                new_cell.burn_time = t_sat;
                if (t_sat >= steps)
                    new_cell.state = ST_BURNT;
            end
            else if (center_reg.state == ST_UNBURNT)
            begin
                if (center_reg.energy >= thr)
                    new_cell.state = ST_BURNING;
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = {cmd.cell_col, cmd.cell_row};
        ram_wdata = {cmd.load_state, cmd.load_material, cmd.load_energy, cmd.load_burn_time};
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we = cmd_acc && (cmd.kind == KIND_LOAD) && cmd_inside;
            end
            S_SCAN:
            begin
                ram_addr = {nx[COL_W-1:0], ny[ROW_W-1:0]};
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_addr  = {x_reg, y_reg};
                ram_wdata = new_cell;
            end
            default: ;
        endcase
    end

    // tap results, taken in the cycle after the read was issued
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && k_reg == '0)
        begin
            sum_reg <= '0;
            nb_reg  <= 1'b0;
        end
        else if (p_valid_reg)
        begin
            if (p_k_reg == '0)
            begin
                center_reg <= rd_cell;
            end
            else if (p_inb_reg && rd_cell.state == ST_BURNING)
            begin
                nb_reg <= 1'b1;
                if (is_fuel(rd_cell.material))
                    sum_reg <= sum_reg + {3'd0, cfg_eff.emission};
            end
        end
        p_inb_reg <= tap_inb;
        p_k_reg   <= k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            k_reg         <= '0;
            p_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_kind_reg  <= '0;
            rsp_cell_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            p_valid_reg <= (state_reg == S_SCAN);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        rsp_kind_reg <= cmd.kind;
                        rsp_cell_reg <= '0;
                        if (cmd.kind == KIND_GEN)
                        begin
                            pass_reg  <= 1'b0;
                            x_reg     <= '0;
                            y_reg     <= '0;
                            k_reg     <= '0;
                            state_reg <= S_SCAN;
                        end
                        else if (cmd.kind == KIND_READ && cmd_inside)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            rsp_valid_reg <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    rsp_cell_reg  <= rd_cell;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (k_reg == LAST_TAP)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= S_SCAN;
                    if (!y_last)
                    begin
                        y_reg <= y_reg + 7'd1;
                    end
                    else
                    begin
                        y_reg <= '0;
                        if (!x_last)
                        begin
                            x_reg <= x_reg + 8'd1;
                        end
                        else
                        begin
                            x_reg <= '0;
                            if (!pass_reg)
                            begin
                                pass_reg <= 1'b1;
                            end
                            else
                            begin
                                pass_reg      <= 1'b0;
                                rsp_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.reply_kind    = rsp_kind_reg;
    assign rsp.out_state     = rsp_cell_reg.state;
    assign rsp.out_material  = rsp_cell_reg.material;
    assign rsp.out_energy    = rsp_cell_reg.energy;
    assign rsp.out_burn_time = rsp_cell_reg.burn_time;

    a_cmd_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> (!rsp.valid || rsp.ready))
        else $error("command taken while response slot busy");

    a_read_responds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> rsp.valid)
        else $error("read did not produce a response");

    a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_SCAN || state_reg == S_IDLE))
        else $error("bad state after cell write back");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (p_valid_reg && p_k_reg == LAST_TAP))
        else $error("drain without last tap in flight");

endmodule

`default_nettype wire
